>>> sv/rtc_pkg.sv
// Shared types, constants and calendar helpers for the RTC calendar counter.
package rtc_pkg;

	localparam logic [7:0] TICKS_LAST_RESET = 8'd199;
	localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
	localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

	// Zero-based month indexes that need special handling.
	localparam logic [3:0] MONTH_FEB = 4'd1;
	localparam logic [3:0] MONTH_APR = 4'd3;
	localparam logic [3:0] MONTH_JUN = 4'd5;
	localparam logic [3:0] MONTH_SEP = 4'd8;
	localparam logic [3:0] MONTH_NOV = 4'd10;

	localparam logic [4:0] DAYS_LONG = 5'd31;
	localparam logic [4:0] DAYS_SHORT = 5'd30;
	localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
	localparam logic [4:0] DAYS_FEB = 5'd28;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} rtc_op_t;

	typedef struct packed {
		logic [7:0] tick;
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] day_idx;
		logic [3:0] mon_idx;
		logic [7:0] year;
	} rtc_state_t;

	typedef struct packed {
		rtc_op_t    op;
		logic [4:0] day;
		logic [3:0] month;
		logic [7:0] year;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} rtc_item_t;

	typedef struct packed {
		rtc_state_t state;
		logic       sec_pulse;
		logic       min_pulse;
	} rtc_next_t;

	// Days in a month; any index above December counts as a long month.
	function automatic logic [4:0] month_length(input logic [3:0] mon_idx,
			input logic [7:0] year);
		logic [4:0] len;
		case (mon_idx) inside
			MONTH_FEB: len = (year[1:0] == 2'b00) ? DAYS_FEB_LEAP : DAYS_FEB;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
			default: len = DAYS_LONG;
		endcase
		return len;
	endfunction

endpackage

>>> sv/rtc_next.sv
// Next-state logic of the calendar: one tick carry chain or one load.
module rtc_next (
	input  rtc_pkg::rtc_state_t state,
	input  rtc_pkg::rtc_item_t  item,
	input  logic [7:0]          tick_last,
	output rtc_pkg::rtc_next_t  nxt
);
	import rtc_pkg::*;

	rtc_state_t s;
	logic       sp;
	logic       mp;
	logic [5:0] next_day;

	always_comb begin
		s = state;
		sp = 1'b0;
		mp = 1'b0;
		next_day = {1'b0, state.day_idx};
		if (item.op == OP_SET) begin
			s.day_idx = item.day - 5'd1;
			s.mon_idx = item.month - 4'd1;
			s.year = item.year;
			s.hour = item.hour;
			s.min = item.minute;
			s.sec = item.second;
		end else begin
			if (state.tick == tick_last) begin
				s.tick = '0;
				s.sec = state.sec + 6'd1;
				sp = 1'b1;
			end else begin
				s.tick = state.tick + 8'd1;
			end
			if (s.sec >= SECONDS_PER_MINUTE) begin
				s.sec = '0;
				s.min = s.min + 6'd1;
				mp = 1'b1;
			end
			if (s.min >= MINUTES_PER_HOUR) begin
				s.min = '0;
				s.hour = s.hour + 5'd1;
			end
			if (s.hour >= HOURS_PER_DAY) begin
				s.hour = '0;
				next_day = next_day + 6'd1;
			end
			// A day index past the month's end, even a loaded one, rolls the month.
			if (next_day >= {1'b0, month_length(state.mon_idx, state.year)}) begin
				s.day_idx = '0;
				s.mon_idx = state.mon_idx + 4'd1;
			end else begin
				s.day_idx = next_day[4:0];
			end
			if (s.mon_idx >= MONTHS_PER_YEAR) begin
				s.mon_idx = '0;
				s.year = state.year + 8'd1;
			end
		end
	end

	assign nxt.state = s;
	assign nxt.sec_pulse = sp;
	assign nxt.min_pulse = mp;

endmodule

>>> sv/rtc_calendar_counter_unit.sv
// Top level of the real-time clock and calendar counter.
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_stall     operation, set_day .. set_second
//  out      output     out_valid / out_stall   day .. sub_tick, second_pulse, minute_pulse
//  cfg      input      cfg_valid / cfg_ready   cfg_data (last tick count per second)
//
// Each item is held in the input register and then updates the calendar registers and
// the result register at once, and one item is taken every cycle while the output
// is not stalled. The carry chain from sub-second count to year sets the path.
// Reset puts the calendar at 2000-01-01 00:00:00 and the tick limit at 199.
// A stalled result holds the calendar; the input register still takes one more item.
module rtc_calendar_counter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [4:0] set_day,
	input  logic [3:0] set_month,
	input  logic [7:0] set_year,
	input  logic [4:0] set_hour,
	input  logic [5:0] set_minute,
	input  logic [5:0] set_second,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] day,
	output logic [3:0] month,
	output logic [7:0] year,
	output logic [4:0] hour,
	output logic [5:0] minute,
	output logic [5:0] second,
	output logic [7:0] sub_tick,
	output logic       second_pulse,
	output logic       minute_pulse,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import rtc_pkg::*;

	logic       valid_s1;
	rtc_item_t  item_s1;
	rtc_state_t state_q;
	logic [7:0] tick_last_q;
	logic       out_valid_q;
	logic       sec_pulse_q;
	logic       min_pulse_q;
	rtc_next_t  nxt;
	logic       in_take;
	logic       advance;

	assign advance = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op <= rtc_op_t'(operation);
			item_s1.day <= set_day;
			item_s1.month <= set_month;
			item_s1.year <= set_year;
			item_s1.hour <= set_hour;
			item_s1.minute <= set_minute;
			item_s1.second <= set_second;
		end
	end

	rtc_next u_next (
		.state     (state_q),
		.item      (item_s1),
		.tick_last (tick_last_q),
		.nxt       (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_last_q <= TICKS_LAST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_last_q <= cfg_data;
		end
	end

	// The calendar registers change only when a result is loaded, so they double
	// as the held result while the output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
			sec_pulse_q <= 1'b0;
			min_pulse_q <= 1'b0;
		end else if (advance) begin
			state_q <= nxt.state;
			out_valid_q <= 1'b1;
			sec_pulse_q <= nxt.sec_pulse;
			min_pulse_q <= nxt.min_pulse;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign day = state_q.day_idx + 5'd1;
	assign month = state_q.mon_idx + 4'd1;
	assign year = state_q.year;
	assign hour = state_q.hour;
	assign minute = state_q.min;
	assign second = state_q.sec;
	assign sub_tick = state_q.tick;
	assign second_pulse = sec_pulse_q;
	assign minute_pulse = min_pulse_q;

	a_set_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op == OP_SET |=> !second_pulse && !minute_pulse)
		else $error("set item produced a pulse");

	a_min_pulse_sec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && minute_pulse |-> second == 6'd0)
		else $error("minute pulse without seconds at zero");

	a_sec_pulse_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && second_pulse |-> sub_tick == 8'd0)
		else $error("second pulse without sub-second count at zero");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with room to move");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("item advanced without a result");

endmodule

>>> tb/tb_rtc_calendar_counter_unit.sv
// Self-checking testbench for the RTC calendar counter: directed table, random phases, predictor.
module tb_rtc_calendar_counter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rtc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int NO_CFG = -1;
	localparam int RANDOM_CFG = -2;
	localparam int DIR_ROWS = 21;
	localparam int PHASES = 8;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [7:0] year;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [7:0] sub_tick;
		logic       sec_pulse;
		logic       min_pulse;
	} cal_result_t;

	typedef struct {
		bit [7:0] sub;
		bit [5:0] sec;
		bit [5:0] minute;
		bit [4:0] hr;
		bit [4:0] day_idx;
		bit [3:0] mon_idx;
		bit [7:0] yr;
	} cal_state_t;

	typedef struct {
		int          cfg;
		rtc_item_t   item;
		bit          typed;
		cal_result_t want;
	} dir_row_t;

	typedef struct {
		int ticks_last;
		int send_pct;
		int stall_pct;
		int items;
		bit hold;
	} phase_t;

	localparam rtc_item_t TICK_ITEM = '{OP_TICK, 5'd0, 4'd0, 8'd0, 5'd0, 6'd0, 6'd0};
	localparam cal_result_t NO_WANT = '0;

	// A typed row is checked against the listed values instead of the predictor output.
	dir_row_t dir_table [DIR_ROWS] = '{
		'{NO_CFG, TICK_ITEM, 1'b1,
			'{5'd1, 4'd1, 8'd0, 5'd0, 6'd0, 6'd0, 8'd1, 1'b0, 1'b0}},
		'{NO_CFG, '{OP_SET, 5'd31, 4'd12, 8'd255, 5'd23, 6'd59, 6'd59}, 1'b1,
			'{5'd31, 4'd12, 8'd255, 5'd23, 6'd59, 6'd59, 8'd1, 1'b0, 1'b0}},
		'{1, TICK_ITEM, 1'b1,
			'{5'd1, 4'd1, 8'd0, 5'd0, 6'd0, 6'd0, 8'd0, 1'b1, 1'b1}},
		'{0, '{OP_SET, 5'd29, 4'd2, 8'd4, 5'd23, 6'd59, 6'd59}, 1'b0, NO_WANT},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, '{OP_SET, 5'd28, 4'd2, 8'd5, 5'd23, 6'd59, 6'd59}, 1'b0, NO_WANT},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, '{OP_SET, 5'd30, 4'd4, 8'd0, 5'd23, 6'd59, 6'd59}, 1'b0, NO_WANT},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, '{OP_SET, 5'd0, 4'd0, 8'd10, 5'd0, 6'd0, 6'd0}, 1'b1,
			'{5'd0, 4'd0, 8'd10, 5'd0, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0}},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, '{OP_SET, 5'd31, 4'd2, 8'd1, 5'd31, 6'd63, 6'd63}, 1'b1,
			'{5'd31, 4'd2, 8'd1, 5'd31, 6'd63, 6'd63, 8'd0, 1'b0, 1'b0}},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, '{OP_SET, 5'd15, 4'd13, 8'd7, 5'd24, 6'd60, 6'd60}, 1'b0, NO_WANT},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, '{OP_SET, 5'd30, 4'd15, 8'd255, 5'd23, 6'd59, 6'd59}, 1'b0, NO_WANT},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, '{OP_SET, 5'd31, 4'd6, 8'd20, 5'd12, 6'd30, 6'd0}, 1'b0, NO_WANT},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT},
		'{255, TICK_ITEM, 1'b0, NO_WANT},
		'{NO_CFG, TICK_ITEM, 1'b0, NO_WANT}
	};

	// The first phase starts with the sub-second count above the register and must wrap.
	phase_t phases [PHASES] = '{
		'{0, 0, 0, 350, 1'b0},
		'{1, 52, 0, 200, 1'b0},
		'{3, 0, 52, 200, 1'b0},
		'{2, 6, 6, 200, 1'b0},
		'{1, 0, 0, 100, 1'b1},
		'{199, 52, 52, 100, 1'b0},
		'{RANDOM_CFG, 6, 6, 100, 1'b0},
		'{0, 0, 0, 100, 1'b1}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       operation = 1'b0;
	logic [4:0] set_day = '0;
	logic [3:0] set_month = '0;
	logic [7:0] set_year = '0;
	logic [4:0] set_hour = '0;
	logic [5:0] set_minute = '0;
	logic [5:0] set_second = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] day;
	logic [3:0] month;
	logic [7:0] year;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;
	logic [7:0] sub_tick;
	logic       second_pulse;
	logic       minute_pulse;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	cal_state_t  cal;
	bit [7:0]    ticks_last;
	cal_result_t pending_times [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          send_pct = 0;
	int          stall_pct = 0;
	logic        hold_trig = 1'b0;
	logic        hold_armed = 1'b0;
	int          hold_left = 0;

	rtc_calendar_counter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.set_day(set_day),
		.set_month(set_month),
		.set_year(set_year),
		.set_hour(set_hour),
		.set_minute(set_minute),
		.set_second(set_second),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.day(day),
		.month(month),
		.year(year),
		.hour(hour),
		.minute(minute),
		.second(second),
		.sub_tick(sub_tick),
		.second_pulse(second_pulse),
		.minute_pulse(minute_pulse),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int unsigned days_in_month(input bit [3:0] mon_idx, input bit [7:0] yr);
		if (mon_idx == MONTH_FEB)
			return (yr % 4 == 0) ? 29 : 28;
		if (mon_idx == MONTH_APR || mon_idx == MONTH_JUN || mon_idx == MONTH_SEP ||
				mon_idx == MONTH_NOV)
			return 30;
		return 31;
	endfunction

	function automatic cal_result_t advance_calendar(input rtc_item_t it);
		cal_result_t r;
		int unsigned next_day;
		r.sec_pulse = 1'b0;
		r.min_pulse = 1'b0;
		if (it.op == OP_SET) begin
			cal.day_idx = it.day - 5'd1;
			cal.mon_idx = it.month - 4'd1;
			cal.yr = it.year;
			cal.hr = it.hour;
			cal.minute = it.minute;
			cal.sec = it.second;
		end else begin
			if (cal.sub == ticks_last) begin
				cal.sub = '0;
				cal.sec = cal.sec + 6'd1;
				r.sec_pulse = 1'b1;
			end else begin
				cal.sub = cal.sub + 8'd1;
			end
			if (cal.sec >= SECONDS_PER_MINUTE) begin
				cal.sec = '0;
				cal.minute = cal.minute + 6'd1;
				r.min_pulse = 1'b1;
			end
			if (cal.minute >= MINUTES_PER_HOUR) begin
				cal.minute = '0;
				cal.hr = cal.hr + 5'd1;
			end
			next_day = cal.day_idx;
			if (cal.hr >= HOURS_PER_DAY) begin
				cal.hr = '0;
				next_day = next_day + 1;
			end
			// A day past the end of the month, however it got there, starts the next month.
			if (next_day + 1 > days_in_month(cal.mon_idx, cal.yr)) begin
				cal.day_idx = '0;
				cal.mon_idx = cal.mon_idx + 4'd1;
			end else begin
				cal.day_idx = 5'(next_day);
			end
			if (cal.mon_idx >= MONTHS_PER_YEAR) begin
				cal.mon_idx = '0;
				cal.yr = cal.yr + 8'd1;
			end
		end
		r.day = cal.day_idx + 5'd1;
		r.month = cal.mon_idx + 4'd1;
		r.year = cal.yr;
		r.hour = cal.hr;
		r.minute = cal.minute;
		r.second = cal.sec;
		r.sub_tick = cal.sub;
		return r;
	endfunction

	function automatic string show_time(input cal_result_t r);
		return $sformatf("%0d/%0d/%0d %0d:%0d:%0d sub=%0d sp=%0b mp=%0b", r.day, r.month,
			r.year, r.hour, r.minute, r.second, r.sub_tick, r.sec_pulse, r.min_pulse);
	endfunction

	function automatic rtc_item_t random_item();
		rtc_item_t it;
		int unsigned pick;
		int unsigned mon;
		// Fields a tick ignores still get random bits.
		it.op = OP_TICK;
		it.day = 5'($urandom_range(0, 31));
		it.month = 4'($urandom_range(0, 15));
		it.year = 8'($urandom_range(0, 255));
		it.hour = 5'($urandom_range(0, 31));
		it.minute = 6'($urandom_range(0, 63));
		it.second = 6'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		if (pick < 82)
			return it;
		it.op = OP_SET;
		if (pick < 94) begin
			// Close to midnight at the end of a month, so carries ripple all the way up.
			mon = $urandom_range(1, 12);
			it.month = 4'(mon);
			it.day = 5'(days_in_month(4'(mon - 1), it.year) - $urandom_range(0, 1));
			it.hour = 5'd23;
			it.minute = 6'(59 - $urandom_range(0, 1));
			it.second = 6'($urandom_range(50, 59));
		end else if (pick < 97) begin
			it.day = 5'($urandom_range(1, 31));
			it.month = 4'($urandom_range(1, 12));
			it.hour = 5'($urandom_range(0, 23));
			it.minute = 6'($urandom_range(0, 59));
			it.second = 6'($urandom_range(0, 59));
		end
		return it;
	endfunction

	task automatic offer(input rtc_item_t it, input bit typed, input cal_result_t want);
		cal_result_t got;
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		set_day <= it.day;
		set_month <= it.month;
		set_year <= it.year;
		set_hour <= it.hour;
		set_minute <= it.minute;
		set_second <= it.second;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = advance_calendar(it);
		pending_times.push_back(typed ? want : got);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_times.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_ticks_last(input bit [7:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		ticks_last = value;
	endtask

	// Long receiver hold-off, started by toggling hold_trig.
	always @(posedge clk) begin
		if (hold_trig != hold_armed) begin
			hold_armed <= hold_trig;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : result_check
		cal_result_t seen;
		cal_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{day, month, year, hour, minute, second, sub_tick, second_pulse,
				minute_pulse};
			if (pending_times.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected item %s", $realtime, show_time(seen));
			end else begin
				want = pending_times.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch, expected %s, got %s", $realtime,
							show_time(want), show_time(seen));
				end
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		cal = '{default: '0};
		ticks_last = TICKS_LAST_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_table[i]) begin
			if (dir_table[i].cfg != NO_CFG)
				write_ticks_last(8'(dir_table[i].cfg));
			offer(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
		end
		foreach (phases[p]) begin
			if (phases[p].ticks_last == RANDOM_CFG)
				write_ticks_last(8'($urandom_range(0, 255)));
			else
				write_ticks_last(8'(phases[p].ticks_last));
			send_pct = phases[p].send_pct;
			stall_pct = phases[p].stall_pct;
			if (phases[p].hold)
				hold_trig <= ~hold_trig;
			repeat (phases[p].items)
				offer(random_item(), 1'b0, NO_WANT);
		end
		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_times.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> rtc_calendar_counter_unit.f
sv/rtc_pkg.sv
sv/rtc_next.sv
sv/rtc_calendar_counter_unit.sv
tb/tb_rtc_calendar_counter_unit.sv
